// File: design/htm_pkg.sv
// ---------------------------------------------------------------------------
// htm_pkg: shared types and constants for the tone map / sRGB encoder
// Field widths, curve codes, register indexes, fixed-point constants and the
// power-term lookup table of the sRGB transfer curve.
// ---------------------------------------------------------------------------
package htm_pkg;

  // field widths
  localparam int XW      = 24;   // linear channel, Q7.16 signed / exposed Q8.16
  localparam int OW      = 16;   // encoded channel, Q0.16
  localparam int CFG_IW  = 3;    // register index width
  localparam int CFG_DW  = 24;   // register data width
  localparam int YW      = 17;   // curve output, Q0.16 with 1.0 representable
  localparam int PW      = 47;   // exposure product width

  // power-term table geometry
  localparam int OETF_TABLE_BITS = 10;
  localparam int OETF_TBL_N      = 1 << OETF_TABLE_BITS;
  localparam int FRAC_BITS       = 16 - OETF_TABLE_BITS;
  localparam int IDX_W           = OETF_TABLE_BITS + 1;

  // divider geometry
  localparam int NUM_W = 51;
  localparam int DEN_W = 34;
  localparam int QW    = 17;

  // back pipeline: three curve stages, divider, three encode stages
  localparam int BACK_DEPTH = 3 + QW + 3;

  // queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = 2;

  // fixed-point constants
  localparam int ONE_Q16    = 65536;
  localparam int ACES_KA    = 164495;
  localparam int ACES_KB    = 1966;
  localparam int ACES_KC    = 159252;
  localparam int ACES_KD    = 38666;
  localparam longint ACES_KE_RND = 64'd9175 * 64'd65536 + 64'd32768;
  localparam int LIN_THRESH = 205;
  localparam int LIN_SLOPE  = 846725;
  localparam int PW_SCALE   = 69140;
  localparam int PW_OFFSET  = 3604;

  // register reset values
  localparam logic [CFG_DW-1:0] GAIN_RST  = 24'd65536;
  localparam logic [CFG_DW-1:0] FLOOR_RST = 24'd0;
  localparam logic [CFG_DW-1:0] ROOF_RST  = 24'd16777215;
  localparam logic [CFG_DW-1:0] CEIL_RST  = 24'd4194304;

  typedef enum logic [1:0] {
    CURVE_SAT      = 2'd0,
    CURVE_REINHARD = 2'd1,
    CURVE_ACES     = 2'd2,
    CURVE_ACES_ALT = 2'd3
  } curve_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_GAIN  = 3'd0,
    REG_FLOOR = 3'd1,
    REG_ROOF  = 3'd2,
    REG_CEIL  = 3'd3,
    REG_CURVE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_DW-1:0] gain;
    logic [CFG_DW-1:0] exp_floor;
    logic [CFG_DW-1:0] exp_roof;
    logic [CFG_DW-1:0] ceiling;
    curve_t            curve;
  } cfg_t;

  typedef struct packed {
    logic [XW-1:0] r;
    logic [XW-1:0] g;
    logic [XW-1:0] b;
  } pix_x_t;

  typedef logic [YW-1:0] oetf_rom_t [0:OETF_TBL_N];

  // floor of the square root, result below 2^21
  function automatic logic [63:0] isqrt_floor(input logic [63:0] v);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] m;
    lo = 64'd0;
    hi = 64'd1 << 21;
    for (int k = 0; k < 24; k++) begin
      if (hi - lo > 64'd1) begin
        m = (lo + hi) >> 1;
        if (m * m <= v) lo = m;
        else hi = m;
      end
    end
    return lo;
  endfunction

  // floor of the cube root, result below 2^21
  function automatic logic [63:0] icbrt_floor(input logic [63:0] v);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] m;
    lo = 64'd0;
    hi = 64'd1 << 21;
    for (int k = 0; k < 24; k++) begin
      if (hi - lo > 64'd1) begin
        m = (lo + hi) >> 1;
        if (m * m * m <= v) lo = m;
        else hi = m;
      end
    end
    return lo;
  endfunction

  // entry i = (i / 2^B)^(5/12) in Q16, as cbrt * sqrt(sqrt(cbrt))
  function automatic oetf_rom_t build_oetf_rom();
    oetf_rom_t   rom;
    logic [63:0] c;
    logic [63:0] s;
    logic [63:0] q;
    logic [63:0] pr;
    for (int i = 0; i <= OETF_TBL_N; i++) begin
      c  = icbrt_floor(64'(i) << (60 - OETF_TABLE_BITS));
      s  = isqrt_floor(c << 20);
      q  = isqrt_floor(s << 20);
      pr = (c * q + (64'd1 << 23)) >> 24;
      rom[i] = YW'(pr);
    end
    return rom;
  endfunction

  localparam oetf_rom_t OETF_ROM = build_oetf_rom();

endpackage

// File: design/htm_in_if.sv
// ---------------------------------------------------------------------------
// htm_in_if: linear pixel channel
// Valid/ready channel carrying one signed Q7.16 RGB pixel per beat.
// ---------------------------------------------------------------------------
interface htm_in_if
  import htm_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic signed [XW-1:0] red_in;
  logic signed [XW-1:0] green_in;
  logic signed [XW-1:0] blue_in;

  modport source(output valid, output red_in, output green_in, output blue_in,
                 input ready);
  modport sink(input valid, input red_in, input green_in, input blue_in,
               output ready);
endinterface

// File: design/htm_out_if.sv
// ---------------------------------------------------------------------------
// htm_out_if: encoded pixel channel
// Valid/ready channel carrying one Q0.16 sRGB pixel per beat.
// ---------------------------------------------------------------------------
interface htm_out_if
  import htm_pkg::*;
();
  logic          valid;
  logic          ready;
  logic [OW-1:0] red_out;
  logic [OW-1:0] green_out;
  logic [OW-1:0] blue_out;

  modport source(output valid, output red_out, output green_out, output blue_out,
                 input ready);
  modport sink(input valid, input red_out, input green_out, input blue_out,
               output ready);
endinterface

// File: design/htm_cfg_if.sv
// ---------------------------------------------------------------------------
// htm_cfg_if: register write channel
// Valid/ready channel carrying a register index and write data per beat.
// ---------------------------------------------------------------------------
interface htm_cfg_if
  import htm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// File: design/htm_front.sv
// ---------------------------------------------------------------------------
// htm_front: exposure stage
// Accepts a pixel beat, multiplies each positive channel by the clamped
// exposure, then rounds and clips it to the ceiling on the way into the queue.
// ---------------------------------------------------------------------------
module htm_front
  import htm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  htm_in_if.sink   in_bus,
  input  cfg_t     cfg,
  input  logic     q_full,
  output logic     q_push,
  output pix_x_t   q_data
);

  logic          f_v_r;
  logic [PW-1:0] prod_r [0:2];
  logic          pos_r  [0:2];
  logic          accept;
  logic [XW-1:0] e_lim;
  logic [XW-1:0] e_use;
  logic [XW-1:0] x_in   [0:2];
  logic [XW-1:0] x_clip [0:2];
  logic [31:0]   xe     [0:2];

  assign x_in[0] = in_bus.red_in;
  assign x_in[1] = in_bus.green_in;
  assign x_in[2] = in_bus.blue_in;

  // handshake, queue space frees the stage
  assign in_bus.ready = !f_v_r || !q_full;
  assign accept       = in_bus.valid && in_bus.ready;
  assign q_push       = f_v_r && !q_full;

  // exposure clamp, floor wins over roof
  always_comb begin
    e_lim = (cfg.gain > cfg.exp_roof) ? cfg.exp_roof : cfg.gain;
    e_use = (e_lim < cfg.exp_floor) ? cfg.exp_floor : e_lim;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (accept) begin
      f_v_r <= 1'b1;
    end else if (q_push) begin
      f_v_r <= 1'b0;
    end
  end

  // exposure product per channel
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= PW'(x_in[k][XW-2:0]) * PW'(e_use);
        pos_r[k]  <= !x_in[k][XW-1] && (x_in[k][XW-2:0] != '0);
      end
    end
  end

  // round, clip to ceiling, zero for non-positive input
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xe[k] = 32'(({1'b0, prod_r[k]} + 48'd32768) >> 16);
      if (!pos_r[k]) x_clip[k] = '0;
      else if (xe[k] > 32'(cfg.ceiling)) x_clip[k] = cfg.ceiling;
      else x_clip[k] = xe[k][XW-1:0];
    end
    q_data.r = x_clip[0];
    q_data.g = x_clip[1];
    q_data.b = x_clip[2];
  end

endmodule

// File: design/htm_fifo.sv
// ---------------------------------------------------------------------------
// htm_fifo: exposed pixel queue
// Short queue between the exposure stage and the curve pipeline.
// ---------------------------------------------------------------------------
module htm_fifo
  import htm_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  pix_x_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   pop_valid,
  output pix_x_t pop_data
);

  pix_x_t             mem [0:FIFO_DEPTH-1];
  logic [FIFO_PW-1:0] wr_ptr_r;
  logic [FIFO_PW-1:0] rd_ptr_r;
  logic [FIFO_PW:0]   count_r;

  assign full      = (count_r == (FIFO_PW+1)'(FIFO_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

endmodule

// File: design/htm_chan.sv
// ---------------------------------------------------------------------------
// htm_chan: curve and encode datapath for one channel
// Curve terms, a one-bit-per-stage restoring divider, then the sRGB curve
// with its interpolated power table. Every stage moves on adv.
// ---------------------------------------------------------------------------
module htm_chan
  import htm_pkg::*;
(
  input  logic          clk,
  input  logic          adv,
  input  curve_t        curve,
  input  logic [XW-1:0] x_in,
  output logic [OW-1:0] code_out
);

  localparam int MW = YW + FRAC_BITS + 1;
  localparam logic [YW-1:0] Y_ONE = YW'(ONE_Q16);

  // stage 1: ACES products
  logic [XW-1:0] x1_r;
  logic [41:0]   pa1_r;
  logic [41:0]   pc1_r;
  logic          sat1_r;
  logic [YW-1:0] ysat1_r;
  // stage 2: second products
  logic [XW-1:0] x2_r;
  logic [49:0]   pn2_r;
  logic [49:0]   pd2_r;
  logic          sat2_r;
  logic [YW-1:0] ysat2_r;
  // stage 3: divider operands
  logic [NUM_W-1:0] num3_r;
  logic [DEN_W-1:0] den3_r;
  logic             sat3_r;
  logic [YW-1:0]    ysat3_r;
  // divider stages
  logic [DEN_W-1:0] rem_r  [0:QW-1];
  logic [DEN_W-1:0] den_r  [0:QW-1];
  logic [QW-1:0]    nlo_r  [0:QW-1];
  logic [QW-1:0]    q_r    [0:QW-1];
  logic             sat_r  [0:QW-1];
  logic [YW-1:0]    ysat_r [0:QW-1];
  // encode stages
  logic [YW-1:0]        lo4_r;
  logic [YW-1:0]        hi4_r;
  logic [FRAC_BITS-1:0] frac4_r;
  logic                 top4_r;
  logic                 lin4_r;
  logic [7:0]           ylin4_r;
  logic [YW-1:0]        p5_r;
  logic [11:0]          linv5_r;
  logic                 lin5_r;
  logic [OW-1:0]        code_r;

  logic [25:0]      ax;
  logic [25:0]      cx;
  logic [33:0]      n_aces;
  logic [33:0]      d_aces;
  logic [NUM_W-1:0] d_sum;
  logic [DEN_W-1:0] d_rein;
  logic [NUM_W-1:0] num_nxt;
  logic [DEN_W-1:0] den_nxt;
  logic [DEN_W-1:0] rem_src [0:QW-1];
  logic [DEN_W-1:0] den_src [0:QW-1];
  logic [QW-1:0]    nlo_src [0:QW-1];
  logic [QW-1:0]    q_src   [0:QW-1];
  logic             sat_src [0:QW-1];
  logic [YW-1:0]    ysat_src[0:QW-1];
  logic [DEN_W:0]   trial   [0:QW-1];
  logic             ge      [0:QW-1];
  logic [YW-1:0]    y;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx1;
  logic [YW-1:0]    diff;
  logic [MW-1:0]    inc;
  logic [YW-1:0]    p_nxt;
  logic [33:0]      r_full;
  logic [YW-1:0]    r;
  logic [27:0]      lin_full;
  logic [OW-1:0]    code_nxt;

  // stage 1: scaled terms and the saturate-only value
  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r    <= x_in;
      pa1_r   <= 42'(ACES_KA) * 42'(x_in);
      pc1_r   <= 42'(ACES_KC) * 42'(x_in);
      sat1_r  <= (curve == CURVE_SAT);
      ysat1_r <= (x_in > XW'(ONE_Q16)) ? Y_ONE : x_in[YW-1:0];
    end
  end

  // stage 2: x*(ax+B) and x*(cx+D)
  always_comb begin
    ax = 26'((pa1_r + 42'd32768) >> 16);
    cx = 26'((pc1_r + 42'd32768) >> 16);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x2_r    <= x1_r;
      pn2_r   <= 50'(x1_r) * 50'(ax + 26'(ACES_KB));
      pd2_r   <= 50'(x1_r) * 50'(cx + 26'(ACES_KD));
      sat2_r  <= sat1_r;
      ysat2_r <= ysat1_r;
    end
  end

  // stage 3: rounded numerator and denominator per curve
  always_comb begin
    n_aces = 34'((pn2_r + 50'd32768) >> 16);
    d_sum  = NUM_W'(pd2_r) + NUM_W'(ACES_KE_RND);
    d_aces = 34'(d_sum >> 16);
    if (d_aces == '0) d_aces = 34'd1;
    d_rein = DEN_W'(x2_r) + DEN_W'(ONE_Q16);
    case (curve)
      CURVE_SAT: begin
        num_nxt = '0;
        den_nxt = DEN_W'(1);
      end
      CURVE_REINHARD: begin
        num_nxt = (NUM_W'(x2_r) << 16) + NUM_W'(d_rein >> 1);
        den_nxt = d_rein;
      end
      default: begin
        num_nxt = (NUM_W'(n_aces) << 16) + NUM_W'(d_aces >> 1);
        den_nxt = d_aces;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num3_r  <= num_nxt;
      den3_r  <= den_nxt;
      sat3_r  <= sat2_r;
      ysat3_r <= ysat2_r;
    end
  end

  // divider: one quotient bit per stage, msb first
  always_comb begin
    rem_src[0]  = num3_r[NUM_W-1:QW];
    den_src[0]  = den3_r;
    nlo_src[0]  = num3_r[QW-1:0];
    q_src[0]    = '0;
    sat_src[0]  = sat3_r;
    ysat_src[0] = ysat3_r;
    for (int s = 1; s < QW; s++) begin
      rem_src[s]  = rem_r[s-1];
      den_src[s]  = den_r[s-1];
      nlo_src[s]  = nlo_r[s-1];
      q_src[s]    = q_r[s-1];
      sat_src[s]  = sat_r[s-1];
      ysat_src[s] = ysat_r[s-1];
    end
    for (int s = 0; s < QW; s++) begin
      trial[s] = {rem_src[s], nlo_src[s][QW-1]};
      ge[s]    = (trial[s] >= {1'b0, den_src[s]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < QW; s++) begin
        rem_r[s]  <= ge[s] ? DEN_W'(trial[s] - {1'b0, den_src[s]})
                           : trial[s][DEN_W-1:0];
        den_r[s]  <= den_src[s];
        nlo_r[s]  <= nlo_src[s] << 1;
        q_r[s]    <= {q_src[s][QW-2:0], ge[s]};
        sat_r[s]  <= sat_src[s];
        ysat_r[s] <= ysat_src[s];
      end
    end
  end

  // encode stage 1: curve value, table lookup
  always_comb begin
    if (sat_r[QW-1]) y = ysat_r[QW-1];
    else if (q_r[QW-1] > Y_ONE) y = Y_ONE;
    else y = q_r[QW-1];
    idx  = y[YW-1:FRAC_BITS];
    idx1 = (idx == IDX_W'(OETF_TBL_N)) ? idx : idx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo4_r   <= OETF_ROM[idx];
      hi4_r   <= OETF_ROM[idx1];
      frac4_r <= y[FRAC_BITS-1:0];
      top4_r  <= (idx == IDX_W'(OETF_TBL_N));
      lin4_r  <= (y <= YW'(LIN_THRESH));
      ylin4_r <= y[7:0];
    end
  end

  // encode stage 2: interpolation and linear segment
  always_comb begin
    diff     = hi4_r - lo4_r;
    inc      = (MW'(diff) * MW'(frac4_r) + MW'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    p_nxt    = (frac4_r != '0 && !top4_r) ? lo4_r + YW'(inc) : lo4_r;
    lin_full = (28'(ylin4_r) * 28'(LIN_SLOPE) + 28'd32768) >> 16;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p5_r    <= p_nxt;
      linv5_r <= lin_full[11:0];
      lin5_r  <= lin4_r;
    end
  end

  // encode stage 3: scale, offset, saturate
  always_comb begin
    r_full = (34'(p5_r) * 34'(PW_SCALE) + 34'd32768) >> 16;
    r      = r_full[YW-1:0];
    if (lin5_r) code_nxt = OW'(linv5_r);
    else if (r <= YW'(PW_OFFSET)) code_nxt = '0;
    else if (r - YW'(PW_OFFSET) > YW'(65535)) code_nxt = '1;
    else code_nxt = OW'(r - YW'(PW_OFFSET));
  end

  always_ff @(posedge clk) begin
    if (adv) code_r <= code_nxt;
  end

  assign code_out = code_r;

endmodule

// File: design/htm_back.sv
// ---------------------------------------------------------------------------
// htm_back: curve and encode pipeline
// Pops exposed pixels from the queue, runs three channel datapaths in lock
// step and holds the result in the last stage until the sink takes it.
// ---------------------------------------------------------------------------
module htm_back
  import htm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  curve_t     curve,
  input  logic       q_valid,
  input  pix_x_t     q_data,
  output logic       q_pop,
  htm_out_if.source  out_bus
);

  logic [BACK_DEPTH-1:0] vld_r;
  logic                  adv;

  // whole pipe moves unless the last stage is held
  assign adv           = !vld_r[BACK_DEPTH-1] || out_bus.ready;
  assign q_pop         = adv && q_valid;
  assign out_bus.valid = vld_r[BACK_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[BACK_DEPTH-2:0], q_pop};
    end
  end

  // channel datapaths
  htm_chan u_red (
    .clk      (clk),
    .adv      (adv),
    .curve    (curve),
    .x_in     (q_data.r),
    .code_out (out_bus.red_out)
  );

  htm_chan u_green (
    .clk      (clk),
    .adv      (adv),
    .curve    (curve),
    .x_in     (q_data.g),
    .code_out (out_bus.green_out)
  );

  htm_chan u_blue (
    .clk      (clk),
    .adv      (adv),
    .curve    (curve),
    .x_in     (q_data.b),
    .code_out (out_bus.blue_out)
  );

endmodule

// File: design/hdr_tonemap_srgb_encode.sv
// ---------------------------------------------------------------------------
// hdr_tonemap_srgb_encode: HDR tone map and sRGB encoder
// Exposure, clip, tone curve (saturate, Reinhard or ACES fit) and sRGB
// transfer curve on each channel of one RGB pixel per beat.
//
//   channel   dir   beat contents
//   in_bus    in    red_in, green_in, blue_in   signed Q7.16
//   out_bus   out   red_out, green_out, blue_out  Q0.16 sRGB
//   cfg_bus   in    index, data (register write, always ready)
//
// One pixel per cycle sustained while the sink is ready; the path is 1
// exposure stage, the queue and 23 back stages (three curve stages, 17
// divider stages, three encode). The 17-stage restoring divider sets the
// latency. Reset is synchronous, active low, and clears all valid state
// and the registers to defaults. A stalled output holds the back pipe;
// the 4-entry queue lets the front keep taking beats until it fills.
// ---------------------------------------------------------------------------
module hdr_tonemap_srgb_encode
  import htm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  htm_in_if.sink     in_bus,
  htm_out_if.source  out_bus,
  htm_cfg_if.sink    cfg_bus
);

  logic [CFG_DW-1:0] gain_r;
  logic [CFG_DW-1:0] floor_r;
  logic [CFG_DW-1:0] roof_r;
  logic [CFG_DW-1:0] ceil_r;
  curve_t            curve_r;
  cfg_t              cfg;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  pix_x_t            q_in;
  pix_x_t            q_out;

  // register writes
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= GAIN_RST;
      floor_r <= FLOOR_RST;
      roof_r  <= ROOF_RST;
      ceil_r  <= CEIL_RST;
      curve_r <= CURVE_ACES;
    end else if (cfg_bus.valid) begin
      case (reg_idx_t'(cfg_bus.index))
        REG_GAIN:  gain_r  <= cfg_bus.data;
        REG_FLOOR: floor_r <= cfg_bus.data;
        REG_ROOF:  roof_r  <= cfg_bus.data;
        REG_CEIL:  ceil_r  <= cfg_bus.data;
        REG_CURVE: curve_r <= curve_t'(cfg_bus.data[1:0]);
        default:   curve_r <= curve_r;
      endcase
    end
  end

  always_comb begin
    cfg.gain      = gain_r;
    cfg.exp_floor = floor_r;
    cfg.exp_roof  = roof_r;
    cfg.ceiling   = ceil_r;
    cfg.curve     = curve_r;
  end

  // exposure front
  htm_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  // queue
  htm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_out)
  );

  // curve and encode back end
  htm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .curve   (curve_r),
    .q_valid (q_valid),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .out_bus (out_bus)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the HDR tone map / sRGB encoder
// Drives linear RGB pixels through the valid/ready input channel, writes the
// exposure, clip and curve registers between phases, and checks every encoded
// pixel against a bit-exact predictor that runs alongside. Sender and receiver
// idle at random, the receiver holds off once for a long stretch.
// ---------------------------------------------------------------------------
module tb;
  import htm_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 20000;
  localparam logic [CFG_IW-1:0] REG_SPARE_5 = 3'd5;
  localparam logic [CFG_IW-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [OW-1:0] r;
    logic [OW-1:0] g;
    logic [OW-1:0] b;
  } srgb_pix_t;

  logic clk;
  logic rst_n;

  htm_in_if  in_bus ();
  htm_out_if out_bus ();
  htm_cfg_if cfg_bus ();

  hdr_tonemap_srgb_encode dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // mirror of the block's registers
  logic [CFG_DW-1:0] gain_q;
  logic [CFG_DW-1:0] floor_q;
  logic [CFG_DW-1:0] roof_q;
  logic [CFG_DW-1:0] ceil_q;
  curve_t            curve_q;

  longint unsigned pow_tbl [0:OETF_TBL_N];
  srgb_pix_t       srgb_expected [$];
  int              err_cnt;
  int              src_idle;
  int              snk_idle;
  logic            hold_req;
  int              hold_left;
  int              quiet_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor of the n-th root (n = 2 or 3) by bisection
  function automatic longint unsigned int_root(longint unsigned v, int n);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned m;
    longint unsigned p;
    lo = 0;
    hi = 64'd1 << 21;
    while (hi - lo > 1) begin
      m = (lo + hi) >> 1;
      p = (n == 3) ? m * m * m : m * m;
      if (p <= v) lo = m;
      else hi = m;
    end
    return lo;
  endfunction

  // power-term table, x^(5/12) in Q16
  task automatic fill_pow_tbl();
    longint unsigned c;
    longint unsigned s;
    longint unsigned q;
    for (int i = 0; i <= OETF_TBL_N; i++) begin
      c = int_root(longint'(i) << (60 - OETF_TABLE_BITS), 3);
      s = int_root(c << 20, 2);
      q = int_root(s << 20, 2);
      pow_tbl[i] = (c * q + (64'd1 << 23)) >> 24;
    end
  endtask

  // tone curve on the exposed value, result Q0.16 capped at 1.0
  function automatic longint unsigned tone_curve(longint unsigned x);
    longint unsigned y;
    longint unsigned d;
    longint unsigned ax;
    longint unsigned cx;
    longint unsigned n;
    case (curve_q)
      CURVE_SAT: y = x;
      CURVE_REINHARD: begin
        d = x + ONE_Q16;
        y = ((x << 16) + d / 2) / d;
      end
      default: begin
        ax = (ACES_KA * x + 32768) >> 16;
        cx = (ACES_KC * x + 32768) >> 16;
        n  = (x * (ax + ACES_KB) + 32768) >> 16;
        d  = (x * (cx + ACES_KD) + ACES_KE_RND) >> 16;
        if (d < 1) d = 1;
        y = ((n << 16) + d / 2) / d;
      end
    endcase
    return (y > ONE_Q16) ? ONE_Q16 : y;
  endfunction

  // sRGB transfer curve: linear segment, else interpolated power term
  function automatic logic [OW-1:0] srgb_encode(longint unsigned y);
    longint unsigned idx;
    longint unsigned frac;
    longint unsigned p;
    longint unsigned r;
    if (y <= LIN_THRESH) return OW'((y * LIN_SLOPE + 32768) >> 16);
    idx  = y >> FRAC_BITS;
    frac = y & ((64'd1 << FRAC_BITS) - 1);
    if (idx > OETF_TBL_N) idx = OETF_TBL_N;
    p = pow_tbl[idx];
    if (frac != 0 && idx < OETF_TBL_N)
      p += ((pow_tbl[idx + 1] - pow_tbl[idx]) * frac + (64'd1 << (FRAC_BITS - 1)))
           >> FRAC_BITS;
    r = (p * PW_SCALE + 32768) >> 16;
    if (r <= PW_OFFSET) return '0;
    r -= PW_OFFSET;
    return (r > 65535) ? 16'hFFFF : OW'(r);
  endfunction

  // one channel: exposure, clip, curve, encode
  function automatic logic [OW-1:0] encode_channel(logic [XW-1:0] raw,
                                                   longint unsigned e);
    longint unsigned xe;
    xe = 0;
    if (!raw[XW-1] && raw != '0) begin
      xe = (longint'(raw) * e + 32768) >> 16;
      if (xe > ceil_q) xe = ceil_q;
    end
    return srgb_encode(tone_curve(xe));
  endfunction

  function automatic srgb_pix_t predict_pixel(logic [XW-1:0] r, logic [XW-1:0] g,
                                              logic [XW-1:0] b);
    longint unsigned e;
    srgb_pix_t       px;
    e = gain_q;
    if (e > roof_q) e = roof_q;
    if (e < floor_q) e = floor_q;
    px.r = encode_channel(r, e);
    px.g = encode_channel(g, e);
    px.b = encode_channel(b, e);
    return px;
  endfunction

  task automatic report_mismatch(string what, int exp_v, int got_v);
    $display("[%0t] mismatch %s: expected %0d got %0d", $time, what, exp_v, got_v);
    err_cnt++;
  endtask

  // register write beat
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_GAIN:  gain_q  = val;
      REG_FLOOR: floor_q = val;
      REG_ROOF:  roof_q  = val;
      REG_CEIL:  ceil_q  = val;
      REG_CURVE: curve_q = curve_t'(val[1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(logic [CFG_DW-1:0] g, logic [CFG_DW-1:0] fl,
                           logic [CFG_DW-1:0] rf, logic [CFG_DW-1:0] cl, curve_t cv);
    write_reg(REG_GAIN, g);
    write_reg(REG_FLOOR, fl);
    write_reg(REG_ROOF, rf);
    write_reg(REG_CEIL, cl);
    write_reg(REG_CURVE, {22'd0, cv});
  endtask

  // one pixel beat, with random sender gaps in front
  task automatic send_pixel(logic [XW-1:0] r, logic [XW-1:0] g, logic [XW-1:0] b);
    if ($urandom_range(99) < src_idle) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle);
    end
    in_bus.valid    <= 1'b1;
    in_bus.red_in   <= r;
    in_bus.green_in <= g;
    in_bus.blue_in  <= b;
    do @(posedge clk); while (!in_bus.ready);
    srgb_expected.push_back(predict_pixel(r, g, b));
  endtask

  // stop sending, wait for all results and let the pipe empty
  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    wait (srgb_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random channel value: mostly the interesting positive range
  function automatic logic [XW-1:0] rand_chan();
    case ($urandom_range(9))
      0, 1:    return XW'($urandom);
      2:       return XW'(-$urandom_range(8388608, 1));
      3:       return XW'($urandom_range(400));
      4:       return XW'($urandom_range(8388607, 1048576));
      default: return XW'($urandom_range(262144));
    endcase
  endfunction

  task automatic send_rand_pixels(int count);
    for (int i = 0; i < count; i++) send_pixel(rand_chan(), rand_chan(), rand_chan());
  endtask

  // extremes and special cases under each curve
  task automatic test_directed();
    logic [XW-1:0] vals [8];
    vals = '{24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'd0, 24'd1, 24'd205, 24'd206,
             24'd65536};
    for (int c = 0; c < 4; c++) begin
      write_reg(REG_CURVE, {22'd0, 2'(c)});
      for (int i = 0; i < 4; i++) send_pixel(vals[2*i], vals[2*i+1], vals[(2*i+5) % 8]);
      settle();
    end
    // crossed exposure bounds, floor wins
    write_all(24'd1000, 24'd131072, 24'd65536, 24'hFFFFFF, CURVE_SAT);
    send_pixel(24'd16384, 24'd32768, 24'd65536);
    settle();
    // full-scale gain and ceiling, then zero ceiling and junk register indexes
    write_all(24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'hFFFFFF, CURVE_REINHARD);
    send_pixel(24'h7FFFFF, 24'd1, 24'd300);
    settle();
    write_reg(REG_CEIL, 24'd0);
    write_reg(REG_SPARE_5, 24'hFFFFFF);
    write_reg(REG_SPARE_7, 24'd0);
    send_pixel(24'h7FFFFF, 24'd65536, 24'd1);
    settle();
  endtask

  // random pixels over several register settings and idle patterns
  task automatic test_random();
    int idle_src [3];
    int idle_snk [3];
    idle_src = '{31, 75, 0};
    idle_snk = '{75, 31, 0};
    for (int m = 0; m < 3; m++) begin
      src_idle = idle_src[m];
      snk_idle = idle_snk[m];
      for (int k = 0; k < 5; k++) begin
        case (k)
          0: write_all(24'd65536, 24'd0, 24'hFFFFFF, 24'd4194304, CURVE_ACES);
          1: write_all(24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'hFFFFFF, CURVE_ACES_ALT);
          2: write_all(24'd0, 24'd0, 24'd0, 24'd0, CURVE_SAT);
          default:
            write_all(24'($urandom_range(1048576)), 24'($urandom_range(65536)),
                      24'($urandom_range(16777215, 32768)),
                      24'($urandom_range(16777215)), curve_t'($urandom_range(3)));
        endcase
        send_rand_pixels(92);
        settle();
      end
    end
  endtask

  // long receiver hold-off while the sender keeps offering beats
  task automatic test_backpressure();
    src_idle = 0;
    snk_idle = 0;
    write_all(24'd98304, 24'd0, 24'hFFFFFF, 24'd4194304, CURVE_ACES);
    hold_req <= 1'b1;
    send_rand_pixels(60);
    settle();
  endtask

  // receiver ready, with the long hold-off counted here
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
      hold_req  <= 1'b0;
    end
    out_bus.ready <= (hold_left == 0) && !hold_req && ($urandom_range(99) >= snk_idle);
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    srgb_pix_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (srgb_expected.size() == 0) begin
        $display("[%0t] result beat with nothing expected", $time);
        err_cnt++;
      end else begin
        want = srgb_expected.pop_front();
        if (out_bus.red_out !== want.r) report_mismatch("red", want.r, out_bus.red_out);
        if (out_bus.green_out !== want.g)
          report_mismatch("green", want.g, out_bus.green_out);
        if (out_bus.blue_out !== want.b) report_mismatch("blue", want.b, out_bus.blue_out);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.red_in    = '0;
    in_bus.green_in  = '0;
    in_bus.blue_in   = '0;
    out_bus.ready    = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = REG_GAIN;
    cfg_bus.data     = '0;
    hold_req         = 1'b0;
    hold_left        = 0;
    quiet_cycles     = 0;
    err_cnt          = 0;
    src_idle         = 31;
    snk_idle         = 75;
    gain_q  = GAIN_RST;
    floor_q = FLOOR_RST;
    roof_q  = ROOF_RST;
    ceil_q  = CEIL_RST;
    curve_q = CURVE_ACES;
    fill_pow_tbl();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults first, before any register write
    send_pixel(24'd65536, 24'd32768, 24'hFFFFFF);
    settle();
    test_directed();
    test_random();
    test_backpressure();

    if (err_cnt == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
design/htm_pkg.sv
design/htm_in_if.sv
design/htm_out_if.sv
design/htm_cfg_if.sv
design/htm_front.sv
design/htm_fifo.sv
design/htm_chan.sv
design/htm_back.sv
design/hdr_tonemap_srgb_encode.sv
tb/tb.sv
